// ===== hw/rtl/recursive_cross_average_blur_defines.svh =====
// Assertion macros shared by the checker of the cross mean blur.
// Depends on nothing; the asserting file provides i_clk and i_rst_n.
`ifndef RECURSIVE_CROSS_AVERAGE_BLUR_DEFINES_SVH
`define RECURSIVE_CROSS_AVERAGE_BLUR_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied
`define RCAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcab check failed");

// Next-cycle implication, ignored while reset is applied
`define RCAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcab check failed");

// Next-cycle implication that also holds across reset
`define RCAB_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rcab check failed");

`endif

// ===== hw/rtl/rcab_pkg.sv =====
// Shared types and constants of the cross mean blur.
// No dependencies; used by rcab_locate, rcab_mean5, the top level and the checker.
package rcab_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int LEN_REG_W  = 11;
    localparam int CNT_REG_W  = 13;
    localparam int LINE_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [LEN_REG_W-1:0] LEN_RESET      = LEN_REG_W'(600);
    localparam logic [CNT_REG_W-1:0] CNT_RESET      = CNT_REG_W'(800);
    localparam logic [CNT_REG_W-1:0] MAX_LINE_COUNT = CNT_REG_W'(4096);

    // Divide a five-term channel sum (at most 1275) by 5: multiply and shift
    localparam int SUM_W      = 11;
    localparam int MEAN_RECIP = 6554;
    localparam int MEAN_SHIFT = 15;
    localparam int PROD_W     = 24;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH = 1'b0,
        CFG_LINE_COUNT  = 1'b1
    } t_cfg_idx;

    // Classification of one pixel by its place in the frame
    typedef struct packed {
        logic has_res;    // a lagged pixel of the line before comes out
        logic interior;   // that lagged pixel gets filtered
        logic last_line;  // the incoming pixel itself comes out as well
        logic frame_end;  // incoming pixel is the last of the line
    } t_loc;

endpackage

// ===== hw/rtl/rcab_line_ram.sv =====
// Single-port-write, single-port-read line store with registered read data.
// No dependencies; instantiated by the top level of the cross mean blur.
module rcab_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/rcab_locate.sv =====
// Line and position counters of the cross mean blur; classifies each pixel.
// Depends on rcab_pkg.
module rcab_locate #(
    parameter int MAX_LINE_LEN = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_frame_start,
    input  logic [rcab_pkg::LEN_REG_W-1:0]  i_line_length,
    input  logic [rcab_pkg::CNT_REG_W-1:0]  i_line_count,
    output logic [$clog2(MAX_LINE_LEN)-1:0] o_y,
    output rcab_pkg::t_loc                  o_loc
);
    import rcab_pkg::*;

    localparam int PW = $clog2(MAX_LINE_LEN);
    localparam int LW = PW + 1;

    logic [PW-1:0]        r_pos;
    logic [LINE_W-1:0]    r_line;
    logic [LW-1:0]        ll;
    logic [CNT_REG_W-1:0] lc;
    logic [LW-1:0]        pos0;
    logic [LW-1:0]        pos1;
    logic [CNT_REG_W-1:0] line0;
    logic [CNT_REG_W-1:0] line1;
    logic [LW-1:0]        n_pos;
    logic [CNT_REG_W-1:0] n_line;

    // Clamp the registers to their usable ranges
    always_comb begin
        if (i_line_length == '0) begin
            ll = LW'(1);
        end else if (32'(i_line_length) > 32'(MAX_LINE_LEN)) begin
            ll = LW'(MAX_LINE_LEN);
        end else begin
            ll = LW'(i_line_length);
        end
        if (i_line_count == '0) begin
            lc = CNT_REG_W'(1);
        end else if (i_line_count > MAX_LINE_COUNT) begin
            lc = MAX_LINE_COUNT;
        end else begin
            lc = i_line_count;
        end
    end

    // Place of the incoming pixel and of the one after it
    always_comb begin
        pos0  = i_frame_start ? '0 : LW'(r_pos);
        line0 = i_frame_start ? '0 : CNT_REG_W'(r_line);
        pos1  = pos0;
        line1 = line0;
        if (pos0 >= ll) begin
            pos1  = '0;
            line1 = line0 + CNT_REG_W'(1);
        end
        if (line1 >= lc) begin
            line1 = '0;
        end
        n_pos  = pos1 + LW'(1);
        n_line = line1;
        if (n_pos >= ll) begin
            n_pos  = '0;
            n_line = line1 + CNT_REG_W'(1);
            if (n_line >= lc) begin
                n_line = '0;
            end
        end
    end

    // Classify the pixel
    always_comb begin
        o_y              = pos1[PW-1:0];
        o_loc.has_res    = (line1 != '0);
        o_loc.last_line  = (line1 == lc - CNT_REG_W'(1));
        o_loc.frame_end  = (pos1 == ll - LW'(1));
        o_loc.interior   = (line1 >= CNT_REG_W'(3))
                        && (line1 + CNT_REG_W'(1) < lc)
                        && (pos1 >= LW'(2))
                        && ((LW+1)'(pos1) + (LW+1)'(2) < (LW+1)'(ll));
    end

    // Advance on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_line <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos[PW-1:0];
            r_line <= n_line[LINE_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/rcab_mean5.sv =====
// Per-channel truncated mean of five packed RGB pixels.
// Depends on rcab_pkg.
module rcab_mean5 (
    input  rcab_pkg::t_pixel i_a,
    input  rcab_pkg::t_pixel i_b,
    input  rcab_pkg::t_pixel i_c,
    input  rcab_pkg::t_pixel i_d,
    input  rcab_pkg::t_pixel i_e,
    output rcab_pkg::t_pixel o_mean
);
    import rcab_pkg::*;

    // One adder tree and reciprocal multiply per channel
    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] prod;

        assign sum = SUM_W'(i_a[ch*CHAN_W +: CHAN_W]) + SUM_W'(i_b[ch*CHAN_W +: CHAN_W])
                   + SUM_W'(i_c[ch*CHAN_W +: CHAN_W]) + SUM_W'(i_d[ch*CHAN_W +: CHAN_W])
                   + SUM_W'(i_e[ch*CHAN_W +: CHAN_W]);
        assign prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
        assign o_mean[ch*CHAN_W +: CHAN_W] = prod[MEAN_SHIFT +: CHAN_W];
    end

endmodule

// ===== hw/rtl/recursive_cross_average_blur.sv =====
// Recursive five-point cross mean blur over a line-by-line RGB pixel stream.
// A result passes through the filter stage register and then the output register.
// Throughput: one pixel per cycle while the output is not stalled; on the last line each
// pixel gives two results, so the output port sets the pace there.
// Reset (synchronous): counters, valids and the previous result clear, the line
// length and count return to 600 and 800; the three line stores are not cleared.
module recursive_cross_average_blur #(
    parameter int MAX_LINE_LEN = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [rcab_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rcab_pkg::CHAN_W-1:0]     i_red,
    input  logic [rcab_pkg::CHAN_W-1:0]     i_green,
    input  logic [rcab_pkg::CHAN_W-1:0]     i_blue,
    input  logic                            i_frame_start,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rcab_pkg::CHAN_W-1:0]     o_out_red,
    output logic [rcab_pkg::CHAN_W-1:0]     o_out_green,
    output logic [rcab_pkg::CHAN_W-1:0]     o_out_blue,
    output logic                            o_last_in_run,
    output logic                            o_frame_done
);
    import rcab_pkg::*;

    localparam int PW = $clog2(MAX_LINE_LEN);

    // configuration registers
    logic [LEN_REG_W-1:0] r_line_length;
    logic [CNT_REG_W-1:0] r_line_count;

    // locate stage
    logic          in_xfer;
    logic [PW-1:0] y;
    logic [PW-1:0] y_next;
    t_loc          loc;
    t_pixel        cur;

    // filter stage
    logic          r_s1_valid;
    logic [PW-1:0] r_s1_y;
    t_loc          r_s1_loc;
    t_pixel        r_s1_cur;
    logic          r_fwd_c;
    logic          r_fwd_n;
    logic          r_fwd_o;
    t_pixel        r_fwd_in_pix;
    t_pixel        r_fwd_out_pix;
    t_pixel        r_prev;
    t_pixel        ram_c_q;
    t_pixel        ram_n_q;
    t_pixel        ram_o_q;
    t_pixel        center;
    t_pixel        below;
    t_pixel        above;
    t_pixel        mean;
    t_pixel        res;
    logic          s1_emits;
    logic          s1_adv;

    // output stage
    logic          r_o_valid;
    t_pixel        r_o_pix;
    logic          r_o_last;
    logic          r_o_done;
    logic          r_p_valid;
    t_pixel        r_p_pix;
    logic          r_p_done;
    logic          out_xfer;
    logic          s2_free;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            r_line_count  <= CNT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[LEN_REG_W-1:0];
                CFG_LINE_COUNT:  r_line_count  <= i_cfg_data[CNT_REG_W-1:0];
            endcase
        end
    end

    // Handshake and stage advance
    assign out_xfer   = r_o_valid && !i_out_stall;
    assign s2_free    = !r_o_valid || (out_xfer && !r_p_valid);
    assign s1_emits   = r_s1_loc.has_res || r_s1_loc.last_line;
    assign s1_adv     = r_s1_valid && (!s1_emits || s2_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign cur        = {i_red, i_green, i_blue};

    rcab_locate #(
        .MAX_LINE_LEN(MAX_LINE_LEN)
    ) u_locate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_frame_start(i_frame_start),
        .i_line_length(r_line_length),
        .i_line_count (r_line_count),
        .o_y          (y),
        .o_loc        (loc)
    );

    assign y_next = y + PW'(1);

    // Original pixels of the pending line, duplicated for two read addresses
    rcab_line_ram #(
        .DEPTH(MAX_LINE_LEN),
        .WIDTH(PIX_W)
    ) u_in_center_ram (
        .i_clk    (i_clk),
        .i_wr_en  (s1_adv),
        .i_wr_addr(r_s1_y),
        .i_wr_data(r_s1_cur),
        .i_rd_en  (in_xfer),
        .i_rd_addr(y),
        .o_rd_data(ram_c_q)
    );

    rcab_line_ram #(
        .DEPTH(MAX_LINE_LEN),
        .WIDTH(PIX_W)
    ) u_in_next_ram (
        .i_clk    (i_clk),
        .i_wr_en  (s1_adv),
        .i_wr_addr(r_s1_y),
        .i_wr_data(r_s1_cur),
        .i_rd_en  (in_xfer),
        .i_rd_addr(y_next),
        .o_rd_data(ram_n_q)
    );

    // Filtered pixels of the line before the pending one
    rcab_line_ram #(
        .DEPTH(MAX_LINE_LEN),
        .WIDTH(PIX_W)
    ) u_out_ram (
        .i_clk    (i_clk),
        .i_wr_en  (s1_adv && r_s1_loc.has_res),
        .i_wr_addr(r_s1_y),
        .i_wr_data(res),
        .i_rd_en  (in_xfer),
        .i_rd_addr(y),
        .o_rd_data(ram_o_q)
    );

    // Load the filter stage; flag reads that race the write of the item ahead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_y        <= y;
            r_s1_loc      <= loc;
            r_s1_cur      <= cur;
            r_fwd_c       <= s1_adv && (y == r_s1_y);
            r_fwd_n       <= s1_adv && (y_next == r_s1_y);
            r_fwd_o       <= s1_adv && r_s1_loc.has_res && (y == r_s1_y);
            r_fwd_in_pix  <= r_s1_cur;
            r_fwd_out_pix <= res;
        end
    end

    // Select forwarded or stored neighbors
    assign center = r_fwd_c ? r_fwd_in_pix  : ram_c_q;
    assign below  = r_fwd_n ? r_fwd_in_pix  : ram_n_q;
    assign above  = r_fwd_o ? r_fwd_out_pix : ram_o_q;

    rcab_mean5 u_mean5 (
        .i_a   (center),
        .i_b   (above),
        .i_c   (r_prev),
        .i_d   (below),
        .i_e   (r_s1_cur),
        .o_mean(mean)
    );

    assign res = r_s1_loc.interior ? mean : center;

    // Hold the latest lagged result for the recursion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (s1_adv && r_s1_loc.has_res) begin
            r_prev <= res;
        end
    end

    // Output register with one pending slot for the second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (s1_adv && s1_emits) begin
            r_o_valid <= 1'b1;
            if (r_s1_loc.has_res) begin
                r_o_pix   <= res;
                r_o_last  <= !r_s1_loc.last_line;
                r_o_done  <= 1'b0;
                r_p_valid <= r_s1_loc.last_line;
                r_p_pix   <= r_s1_cur;
                r_p_done  <= r_s1_loc.frame_end;
            end else begin
                r_o_pix   <= r_s1_cur;
                r_o_last  <= 1'b1;
                r_o_done  <= r_s1_loc.frame_end;
                r_p_valid <= 1'b0;
            end
        end else if (out_xfer) begin
            if (r_p_valid) begin
                r_o_pix   <= r_p_pix;
                r_o_last  <= 1'b1;
                r_o_done  <= r_p_done;
                r_p_valid <= 1'b0;
            end else begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_red     = r_o_pix[2*CHAN_W +: CHAN_W];
    assign o_out_green   = r_o_pix[CHAN_W +: CHAN_W];
    assign o_out_blue    = r_o_pix[0 +: CHAN_W];
    assign o_last_in_run = r_o_last;
    assign o_frame_done  = r_o_done;

endmodule

// ===== hw/rtl/rcab_checker.sv =====
// Port-level checks of the cross mean blur, bound to its top level.
// Depends on rcab_pkg and recursive_cross_average_blur_defines.svh.
`include "recursive_cross_average_blur_defines.svh"

module rcab_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rcab_pkg::CHAN_W-1:0] o_out_red,
    input logic [rcab_pkg::CHAN_W-1:0] o_out_green,
    input logic [rcab_pkg::CHAN_W-1:0] o_out_blue,
    input logic                        o_last_in_run,
    input logic                        o_frame_done
);

    // A stalled result holds
    `RCAB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable({o_out_red, o_out_green, o_out_blue, o_last_in_run, o_frame_done}))

    // The frame's final pixel closes its run
    `RCAB_ASSERT_NOW(a_done_last, o_out_valid && o_frame_done, o_last_in_run)

    // A run that is not closed continues at once with its second result
    `RCAB_ASSERT_NEXT(a_run_cont, o_out_valid && !o_last_in_run && !i_out_stall, o_out_valid && o_last_in_run)

    // Reset empties the output
    `RCAB_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid)

endmodule

bind recursive_cross_average_blur rcab_checker u_rcab_checker (.*);
